@@ design/ptaf_pkg.sv @@
// Package for the port table allocate/find block.
// Holds the request and response item types and the sequencer state type.
// No dependencies; port_table_allocate_find imports it.
package ptaf_pkg;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FIND  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] port_id;
		logic [7:0]  owner_thread;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] port_index;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} seq_state_t;

endpackage

@@ design/ptaf_chan_if.sv @@
// Valid/ready channel interface that carries one item of a given payload type.
// No dependencies; the payload type is supplied by the instantiating scope.
interface ptaf_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/ptaf_store.sv @@
// Port entry storage: valid bits in flip-flops, owner and identifier in memories.
// Reads are registered; one write and one read per cycle. No package dependencies.
module ptaf_store #(
	parameter int PORT_COUNT = 16,
	parameter int IDENT_BITS = 32,
	parameter int OWNER_BITS = 8,
	localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [OWNER_BITS-1:0] wr_owner,
	input  logic [IDENT_BITS-1:0] wr_ident,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic                  rd_valid,
	output logic [OWNER_BITS-1:0] rd_owner,
	output logic [IDENT_BITS-1:0] rd_ident
);

	logic [PORT_COUNT-1:0] valid_q;
	logic [OWNER_BITS-1:0] owner_mem [PORT_COUNT];
	logic [IDENT_BITS-1:0] ident_mem [PORT_COUNT];
	logic                  rd_valid_q;
	logic [OWNER_BITS-1:0] rd_owner_q;
	logic [IDENT_BITS-1:0] rd_ident_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			owner_mem[wr_addr] <= wr_owner;
			ident_mem[wr_addr] <= wr_ident;
		end
		rd_owner_q <= owner_mem[rd_addr];
		rd_ident_q <= ident_mem[rd_addr];
	end

	assign rd_valid = rd_valid_q;
	assign rd_owner = rd_owner_q;
	assign rd_ident = rd_ident_q;

	// An allocation must only ever claim a free entry.
	a_write_to_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !valid_q[wr_addr])
		else $error("write to an entry that is already in use");

endmodule

@@ design/port_table_allocate_find.sv @@
// Port table allocate/find. An accepted item goes from the idle (accept) state through a scan of
// every entry, through the single registered memory read port and the shared owner/identifier
// comparator, to a decide/writeback state that waits while the response register is still full.
// One item is in work at a time, so no new item is accepted until the last one leaves that state.
// The response register lets the next item be accepted while a response waits.
// Reset clears all valid bits at once, so every entry is free immediately after reset.
module port_table_allocate_find
	import ptaf_pkg::*;
#(
	parameter int PORT_COUNT = 16,
	parameter int IDENT_BITS = 32,
	parameter int OWNER_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ptaf_chan_if.sink   req,
	ptaf_chan_if.source rsp
);

	localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int CNT_W = $clog2(PORT_COUNT + 1);

	seq_state_t            state_q, state_d;
	mode_t                 mode_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [IDENT_BITS-1:0] ident_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  chk_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  hit_q, free_q;
	logic [IDX_W-1:0]      hit_idx_q, free_idx_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q, rsp_d;

	logic                  accept, load, wr_en, match, scan_end;
	logic                  rd_valid;
	logic [OWNER_BITS-1:0] rd_owner;
	logic [IDENT_BITS-1:0] rd_ident;

	ptaf_store #(
		.PORT_COUNT (PORT_COUNT),
		.IDENT_BITS (IDENT_BITS),
		.OWNER_BITS (OWNER_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (free_idx_q),
		.wr_owner (owner_q),
		.wr_ident (ident_q),
		.rd_addr  (cnt_q[IDX_W-1:0]),
		.rd_valid (rd_valid),
		.rd_owner (rd_owner),
		.rd_ident (rd_ident)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign match     = rd_valid && (rd_owner == owner_q) && (rd_ident == ident_q);
	assign scan_end  = (cnt_q == CNT_W'(PORT_COUNT));

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		wr_en   = 1'b0;
		rsp_d   = '{status: ST_OK, port_index: '0};
		if (mode_q == MODE_ALLOC) begin
			if (hit_q) begin
				rsp_d.status = ST_DUPLICATE;
			end else if (free_q) begin
				rsp_d.port_index = 4'(free_idx_q);
			end else begin
				rsp_d.status = ST_FULL;
			end
		end else begin
			if (hit_q) begin
				rsp_d.port_index = 4'(hit_idx_q);
			end else begin
				rsp_d.status = ST_NOT_FOUND;
			end
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load    = 1'b1;
					wr_en   = (mode_q == MODE_ALLOC) && !hit_q && free_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q  <= '0;
				chk_s1 <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				chk_s1 <= !scan_end;
				if (!scan_end) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (chk_s1 && match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (chk_s1 && !rd_valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req.data.mode;
			owner_q <= OWNER_BITS'(req.data.owner_thread);
			ident_q <= IDENT_BITS'(req.data.port_id);
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
			if (chk_s1 && match && !hit_q) begin
				hit_idx_q <= idx_s1;
			end
			if (chk_s1 && !rd_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// An accepted item always starts its scan at entry zero.
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN) && (cnt_q == '0) && !chk_s1)
		else $error("scan did not start at entry zero");

	// A comparison is only pending after at least one read was issued.
	a_chk_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> (state_q == S_SCAN) && (cnt_q != '0))
		else $error("comparison pending without an issued read");

	// A response that is not ok carries a zero index.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status != ST_OK)) |-> (rsp_q.port_index == '0))
		else $error("nonzero index on a failed request");

	// A duplicate or a find never claims an entry.
	a_no_dup_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !hit_q && (mode_q == MODE_ALLOC))
		else $error("entry claimed for a duplicate or a find");

endmodule

@@ bench/port_table_allocate_find_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for port_table_allocate_find, with random handshake gaps.
// Depends on ptaf_pkg and ptaf_chan_if; predicts every response with its own port table.
module port_table_allocate_find_tb;
	import ptaf_pkg::*;

	localparam int PORT_COUNT = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]  owner;
		logic [31:0] ident;
	} port_key_t;

	logic clk;
	logic arst_n;

	ptaf_chan_if #(.payload_t(req_t)) req_if ();
	ptaf_chan_if #(.payload_t(rsp_t)) rsp_if ();

	port_table_allocate_find dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	req_t      pending_reqs[$];
	rsp_t      expected_rsps[$];
	port_key_t live_keys[$];

	logic        table_valid [PORT_COUNT] = '{default: 1'b0};
	logic [7:0]  table_owner [PORT_COUNT];
	logic [31:0] table_ident [PORT_COUNT];

	int   item_total = 0;
	int   accepted_count = 0;
	int   mismatch_count = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	function automatic rsp_t predict_table_op(req_t r);
		int   hit;
		int   slot;
		rsp_t outcome;
		hit = -1;
		slot = -1;
		for (int i = 0; i < PORT_COUNT; i++) begin
			if (hit < 0 && table_valid[i] && table_owner[i] == r.owner_thread &&
					table_ident[i] == r.port_id) begin
				hit = i;
			end
			if (slot < 0 && !table_valid[i]) begin
				slot = i;
			end
		end
		outcome.status = ST_OK;
		outcome.port_index = '0;
		if (r.mode == MODE_ALLOC) begin
			if (hit >= 0) begin
				outcome.status = ST_DUPLICATE;
			end else if (slot < 0) begin
				outcome.status = ST_FULL;
			end else begin
				table_valid[slot] = 1'b1;
				table_owner[slot] = r.owner_thread;
				table_ident[slot] = r.port_id;
				outcome.port_index = slot[3:0];
			end
		end else if (hit >= 0) begin
			outcome.port_index = hit[3:0];
		end else begin
			outcome.status = ST_NOT_FOUND;
		end
		return outcome;
	endfunction

	function automatic port_key_t make_key(logic [7:0] owner, logic [31:0] ident);
		port_key_t key;
		key.owner = owner;
		key.ident = ident;
		return key;
	endfunction

	function automatic port_key_t random_key();
		return make_key(8'($urandom_range(0, 255)), $urandom());
	endfunction

	function automatic port_key_t any_live_key();
		return live_keys[$urandom_range(0, live_keys.size() - 1)];
	endfunction

	// A key one bit away from a live one exercises every bit of the comparator.
	function automatic port_key_t near_miss(port_key_t key);
		int bit_pos;
		bit_pos = $urandom_range(0, 39);
		return key ^ (40'd1 << bit_pos);
	endfunction

	task automatic queue_req(mode_t mode, port_key_t key);
		req_t r;
		r.mode = mode;
		r.port_id = key.ident;
		r.owner_thread = key.owner;
		pending_reqs.push_back(r);
	endtask

	function automatic int sender_idle_pct();
		if (accepted_count < item_total / 3) return 11;
		if (accepted_count < 2 * item_total / 3) return 49;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (accepted_count < item_total / 3) return 49;
		if (accepted_count < 2 * item_total / 3) return 11;
		return 0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
			accepted_count <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_rsps.push_back(predict_table_op(req_if.data));
				accepted_count <= accepted_count + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					req_if.data <= pending_reqs.pop_front();
					req_if.valid <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Late in the run the receiver stalls long enough for the request side to back up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (!hold_done && accepted_count >= 5 * item_total / 6) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= $urandom_range(0, 99) >= receiver_idle_pct();
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("Unexpected response: status %0d index %0d",
						rsp_if.data.status, rsp_if.data.port_index);
				end
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_if.data.status !== want.status ||
						rsp_if.data.port_index !== want.port_index) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("Mismatch: expected status %0d index %0d, got status %0d index %0d",
							want.status, want.port_index,
							rsp_if.data.status, rsp_if.data.port_index);
					end
				end
			end
		end
	end

	initial begin
		port_key_t key;
		int        pick;
		arst_n = 1'b0;

		queue_req(MODE_FIND, make_key(8'h00, 32'h0000_0000));
		queue_req(MODE_ALLOC, make_key(8'h00, 32'h0000_0000));
		queue_req(MODE_ALLOC, make_key(8'hFF, 32'hFFFF_FFFF));
		queue_req(MODE_ALLOC, make_key(8'h00, 32'h0000_0000));
		queue_req(MODE_FIND, make_key(8'hFF, 32'hFFFF_FFFF));
		queue_req(MODE_FIND, make_key(8'hFF, 32'h0000_0000));
		queue_req(MODE_FIND, make_key(8'h00, 32'hFFFF_FFFF));
		queue_req(MODE_ALLOC, make_key(8'hFF, 32'h0000_0000));
		queue_req(MODE_ALLOC, make_key(8'h00, 32'hFFFF_FFFF));
		queue_req(MODE_FIND, make_key(8'h00, 32'h0000_0000));
		queue_req(MODE_FIND, make_key(8'h00, 32'h8000_0000));
		live_keys.push_back(make_key(8'h00, 32'h0000_0000));
		live_keys.push_back(make_key(8'hFF, 32'hFFFF_FFFF));
		live_keys.push_back(make_key(8'hFF, 32'h0000_0000));
		live_keys.push_back(make_key(8'h00, 32'hFFFF_FFFF));
		for (int k = 4; k < PORT_COUNT; k++) begin
			key = random_key();
			live_keys.push_back(key);
			queue_req(MODE_ALLOC, key);
		end
		// With the table full, a new key is refused as full and a known one as a duplicate.
		queue_req(MODE_ALLOC, make_key(8'h5A, 32'h1234_5678));
		queue_req(MODE_ALLOC, live_keys[7]);

		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				queue_req(MODE_ALLOC, any_live_key());
			end else if (pick < 23) begin
				queue_req(MODE_ALLOC, near_miss(any_live_key()));
			end else if (pick < 30) begin
				queue_req(MODE_ALLOC, random_key());
			end else if (pick < 65) begin
				queue_req(MODE_FIND, any_live_key());
			end else if (pick < 83) begin
				queue_req(MODE_FIND, near_miss(any_live_key()));
			end else begin
				queue_req(MODE_FIND, random_key());
			end
		end
		item_total = pending_reqs.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_count != item_total || expected_rsps.size() != 0) @(posedge clk);
		repeat (3 * (PORT_COUNT + 3)) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
